FILE: rtl/resource_pool_idle_eviction_core_assert.svh
// Assertion macros shared by the pool checker.
// Each macro expands to one labeled concurrent assertion with reset disable.
`ifndef RESOURCE_POOL_IDLE_EVICTION_CORE_ASSERT_SVH
`define RESOURCE_POOL_IDLE_EVICTION_CORE_ASSERT_SVH

// Same-cycle implication.
`define RPIE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpie assertion failed");

// Next-cycle implication.
`define RPIE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpie assertion failed");

`endif

FILE: rtl/rpie_pkg.sv
// Shared types and constants for the resource pool with idle eviction.
// Used by the interfaces, controller, datapath, top level and checker.
package rpie_pkg;

    localparam int KEY_W   = 32;
    localparam int FRAME_W = 32;
    localparam int SLOT_W  = 4;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    // Register index as decoded from paddr[ADDR_W-1].
    localparam logic REG_MAX_IDLE = 1'b0;
    localparam logic [DATA_W-1:0] MAX_IDLE_RESET = 32'd3;

    typedef enum logic [1:0] {
        FN_REQUEST = 2'd0,
        FN_RETURN  = 2'd1,
        FN_TICK    = 2'd2,
        FN_CLEAR   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_REUSED    = 3'd0,
        ST_NEW       = 3'd1,
        ST_FULL      = 3'd2,
        ST_RETURNED  = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_EVICTED   = 3'd5,
        ST_NONE      = 3'd6,
        ST_IGNORED   = 3'd7
    } t_status;

    typedef struct packed {
        t_func               func;
        logic [KEY_W-1:0]    key;
        logic [FRAME_W-1:0]  frame;
        logic [SLOT_W-1:0]   slot_in;
        logic                slot_in_valid;
    } t_in_item;

    typedef struct packed {
        t_status             status;
        logic [SLOT_W-1:0]   slot_out;
        logic [KEY_W-1:0]    key_out;
        logic                last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REQ,
        S_RET,
        S_EVICT,
        S_FIN
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic take;
        logic inc;
        logic grant_hit;
        logic grant_end;
        logic ret;
        logic evict_step;
        logic fin;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic out_free;
        logic hit;
        logic at_end;
        logic evict;
        logic pend_vld;
    } t_dp_sts;

endpackage

FILE: rtl/rpie_if.sv
// Valid/ready channel interfaces for the pool's input and result streams.
// Depends on rpie_pkg for the payload types.
interface rpie_in_if
    import rpie_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface rpie_out_if
    import rpie_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

FILE: rtl/rpie_ctrl.sv
// Pool sequencer: walks the slots one per cycle unless a held eviction stalls it,
// and issues datapath commands. Depends on rpie_pkg.
module rpie_ctrl
    import rpie_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_func   i_in_func,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in_func)
                        FN_REQUEST: n_state = S_REQ;
                        FN_RETURN:  n_state = S_RET;
                        default:    n_state = S_EVICT;
                    endcase
                end
            end
            S_REQ: begin
                if ((i_sts.hit || i_sts.at_end) && i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_RET: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_EVICT: begin
                if (!(i_sts.evict && i_sts.pend_vld && !i_sts.out_free) && i_sts.at_end) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
            end
            S_REQ: begin
                if (i_sts.hit) begin
                    o_cmd.grant_hit = i_sts.out_free;
                end else if (i_sts.at_end) begin
                    o_cmd.grant_end = i_sts.out_free;
                end else begin
                    o_cmd.inc = 1'b1;
                end
            end
            S_RET: begin
                o_cmd.ret = i_sts.out_free;
            end
            S_EVICT: begin
                // stall only when a held eviction must be pushed out
                if (!(i_sts.evict && i_sts.pend_vld && !i_sts.out_free)) begin
                    o_cmd.evict_step = 1'b1;
                    o_cmd.inc        = !i_sts.at_end;
                end
            end
            S_FIN: begin
                o_cmd.fin = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/rpie_datapath.sv
// Pool storage and result path: slot flags, key and frame memories, scan index,
// held eviction and output register. Depends on rpie_pkg.
module rpie_datapath
    import rpie_pkg::*;
#(
    parameter int POOL_DEPTH = 16,
    parameter int KEY_WIDTH  = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  t_in_item          i_in_item,
    input  logic [DATA_W-1:0] i_max_idle,
    input  logic              i_out_ready,
    output t_dp_sts           o_sts,
    output logic              o_out_valid,
    output t_out_item         o_out_item
);

    localparam int IW = $clog2(POOL_DEPTH);
    localparam int KW = (KEY_WIDTH < KEY_W) ? KEY_WIDTH : KEY_W;

    logic [POOL_DEPTH-1:0] r_valid;
    logic [POOL_DEPTH-1:0] r_busy;
    logic [KW-1:0]         r_key_mem   [POOL_DEPTH];
    logic [FRAME_W-1:0]    r_frame_mem [POOL_DEPTH];
    logic [KW-1:0]         r_key_rd;
    logic [FRAME_W-1:0]    r_frame_rd;

    logic [IW-1:0]         r_idx;
    logic [IW-1:0]         n_idx;
    t_in_item              r_item;

    logic                  r_emp_vld;
    logic [IW-1:0]         r_emp_idx;
    logic                  r_pend_vld;
    logic [IW-1:0]         r_pend_idx;
    logic [KW-1:0]         r_pend_key;

    logic                  r_out_vld;
    t_out_item             r_out;
    t_out_item             n_out;
    logic                  out_load;

    logic [KW-1:0]         req_key;
    logic                  cur_empty;
    logic                  new_ok;
    logic [IW-1:0]         new_idx;
    logic                  sin_ok;
    logic                  ret_ok;
    logic [FRAME_W-1:0]    age;
    logic                  hit;
    logic                  evict;
    logic                  at_end;
    logic                  out_free;
    logic                  mem_we;
    logic                  key_we;
    logic [IW-1:0]         w_idx;

    assign req_key   = r_item.key[KW-1:0];
    assign cur_empty = !r_valid[r_idx];
    assign new_ok    = r_emp_vld || cur_empty;
    assign new_idx   = r_emp_vld ? r_emp_idx : r_idx;
    assign sin_ok    = 32'(r_item.slot_in) < 32'(POOL_DEPTH);
    assign ret_ok    = r_item.slot_in_valid && sin_ok && r_valid[r_idx];
    assign age       = r_item.frame - r_frame_rd;
    assign hit       = r_valid[r_idx] && !r_busy[r_idx] && (r_key_rd == req_key);
    assign evict     = r_valid[r_idx] &&
                       ((r_item.func == FN_CLEAR) || (!r_busy[r_idx] && (age > i_max_idle)));
    assign at_end    = (r_idx == IW'(POOL_DEPTH - 1));
    assign out_free  = !r_out_vld || i_out_ready;

    assign o_sts = '{out_free: out_free, hit: hit, at_end: at_end,
                     evict: evict, pend_vld: r_pend_vld};

    // Scan index; a return points it straight at the named slot.
    always_comb begin
        if (i_cmd.take) begin
            n_idx = (i_in_item.func == FN_RETURN) ? IW'(i_in_item.slot_in) : '0;
        end else if (i_cmd.inc) begin
            n_idx = r_idx + 1'b1;
        end else begin
            n_idx = r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
        if (i_cmd.take) begin
            r_item <= i_in_item;
        end
    end

    // Memories: one write port, read at the next index so data lines up with r_idx.
    assign mem_we = i_cmd.grant_hit || (i_cmd.grant_end && new_ok);
    assign key_we = i_cmd.grant_end && new_ok;
    assign w_idx  = i_cmd.grant_hit ? r_idx : new_idx;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_frame_mem[w_idx] <= r_item.frame;
        end
        if (key_we) begin
            r_key_mem[w_idx] <= req_key;
        end
        r_key_rd   <= r_key_mem[n_idx];
        r_frame_rd <= r_frame_mem[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_busy  <= '0;
        end else begin
            if (i_cmd.grant_hit) begin
                r_busy[r_idx] <= 1'b1;
            end
            if (i_cmd.grant_end && new_ok) begin
                r_valid[new_idx] <= 1'b1;
                r_busy[new_idx]  <= 1'b1;
            end
            if (i_cmd.ret && ret_ok) begin
                r_busy[r_idx] <= 1'b0;
            end
            if (i_cmd.evict_step && evict) begin
                r_valid[r_idx] <= 1'b0;
                r_busy[r_idx]  <= 1'b0;
            end
        end
    end

    // Remember the lowest empty slot seen during a request scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emp_vld <= 1'b0;
        end else if (i_cmd.take) begin
            r_emp_vld <= 1'b0;
        end else if (i_cmd.inc && cur_empty && !r_emp_vld) begin
            r_emp_vld <= 1'b1;
        end
        if (i_cmd.inc && cur_empty && !r_emp_vld) begin
            r_emp_idx <= r_idx;
        end
    end

    // Hold the latest eviction until the scan shows whether it is the final one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
        end else if (i_cmd.take || i_cmd.fin) begin
            r_pend_vld <= 1'b0;
        end else if (i_cmd.evict_step && evict) begin
            r_pend_vld <= 1'b1;
        end
        if (i_cmd.evict_step && evict) begin
            r_pend_idx <= r_idx;
            r_pend_key <= r_key_rd;
        end
    end

    always_comb begin
        out_load = 1'b0;
        n_out    = '{status: ST_NONE, slot_out: '0, key_out: '0, last: 1'b1};
        if (i_cmd.grant_hit) begin
            out_load = 1'b1;
            n_out    = '{status: ST_REUSED, slot_out: SLOT_W'(r_idx),
                         key_out: KEY_W'(req_key), last: 1'b1};
        end else if (i_cmd.grant_end) begin
            out_load = 1'b1;
            if (new_ok) begin
                n_out = '{status: ST_NEW, slot_out: SLOT_W'(new_idx),
                          key_out: KEY_W'(req_key), last: 1'b1};
            end else begin
                n_out = '{status: ST_FULL, slot_out: '0,
                          key_out: KEY_W'(req_key), last: 1'b1};
            end
        end else if (i_cmd.ret) begin
            out_load = 1'b1;
            if (!r_item.slot_in_valid) begin
                n_out = '{status: ST_IGNORED, slot_out: '0, key_out: '0, last: 1'b1};
            end else if (ret_ok) begin
                n_out = '{status: ST_RETURNED, slot_out: r_item.slot_in,
                          key_out: KEY_W'(r_key_rd), last: 1'b1};
            end else begin
                n_out = '{status: ST_NOT_FOUND, slot_out: r_item.slot_in,
                          key_out: '0, last: 1'b1};
            end
        end else if (i_cmd.evict_step && evict && r_pend_vld) begin
            out_load = 1'b1;
            n_out    = '{status: ST_EVICTED, slot_out: SLOT_W'(r_pend_idx),
                         key_out: KEY_W'(r_pend_key), last: 1'b0};
        end else if (i_cmd.fin) begin
            out_load = 1'b1;
            if (r_pend_vld) begin
                n_out = '{status: ST_EVICTED, slot_out: SLOT_W'(r_pend_idx),
                          key_out: KEY_W'(r_pend_key), last: 1'b1};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

FILE: rtl/resource_pool_idle_eviction_core.sv
// Resource pool with idle eviction: request, return, tick and clear over POOL_DEPTH slots.
// Request walks one slot per cycle and registers its result at the first idle match or,
// on a miss, at the last slot. Tick and clear walk every slot, then register their last
// result; return registers its single result directly. A new transfer is taken only once
// the last result is registered and the core is idle; a stalled result holds the walk.
// Synchronous active-low reset empties all slots and sets max_idle_frames to 3.
module resource_pool_idle_eviction_core
    import rpie_pkg::*;
#(
    parameter int POOL_DEPTH = 16,
    parameter int KEY_WIDTH  = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rpie_in_if.sink           i_in,
    rpie_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [DATA_W-1:0] r_max_idle;
    t_dp_cmd           cmd;
    t_dp_sts           sts;
    logic              in_ready;
    logic              out_valid;
    t_out_item         out_item;

    assign pready = 1'b1;
    assign prdata = (paddr[ADDR_W-1] == REG_MAX_IDLE) ? r_max_idle : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_idle <= MAX_IDLE_RESET;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[ADDR_W-1] == REG_MAX_IDLE)) begin
            r_max_idle <= pwdata;
        end
    end

    rpie_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_func  (i_in.item.func),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    rpie_datapath #(
        .POOL_DEPTH (POOL_DEPTH),
        .KEY_WIDTH  (KEY_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_item   (i_in.item),
        .i_max_idle  (r_max_idle),
        .i_out_ready (o_out.ready),
        .o_sts       (sts),
        .o_out_valid (out_valid),
        .o_out_item  (out_item)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    assign o_out.item  = out_item;

endmodule

FILE: rtl/rpie_checker.sv
// Port-level checks for the pool core, attached to the top level by bind.
// Depends on rpie_pkg and the assertion macro header.
`include "resource_pool_idle_eviction_core_assert.svh"

module rpie_checker
    import rpie_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [2:0]        i_status,
    input logic [SLOT_W-1:0] i_slot,
    input logic [KEY_W-1:0]  i_key,
    input logic              i_last
);

    logic                           single_st;
    logic                           none_st;
    logic                           ign_st;
    logic                           zero_tail;
    logic                           in_xfer;
    logic                           out_wait;
    logic [3+SLOT_W+KEY_W:0]        payload;

    // Every operation except tick and clear yields exactly one result.
    assign single_st = i_out_valid &&
                       (i_status == ST_REUSED || i_status == ST_NEW ||
                        i_status == ST_FULL || i_status == ST_RETURNED ||
                        i_status == ST_NOT_FOUND || i_status == ST_IGNORED);
    assign none_st   = i_out_valid && (i_status == ST_NONE);
    assign ign_st    = i_out_valid && (i_status == ST_IGNORED);
    assign zero_tail = (i_slot == '0) && (i_key == '0);
    assign in_xfer   = i_in_valid && i_in_ready;
    assign out_wait  = i_out_valid && !i_out_ready;
    assign payload   = {i_status, i_slot, i_key, i_last};

    `RPIE_ASSERT_IMP(a_single_last, i_clk, i_rst_n, single_st, i_last)

    `RPIE_ASSERT_IMP(a_none_last, i_clk, i_rst_n, none_st, i_last && zero_tail)

    `RPIE_ASSERT_IMP(a_ignored_zero, i_clk, i_rst_n, ign_st, zero_tail)

    // In the cycle after an accepted item the core is busy and not ready.
    `RPIE_ASSERT_NXT(a_busy_after_transfer, i_clk, i_rst_n, in_xfer, !i_in_ready)

    `RPIE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_wait, i_out_valid && $stable(payload))

endmodule

bind resource_pool_idle_eviction_core rpie_checker u_rpie_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.item.status),
    .i_slot      (o_out.item.slot_out),
    .i_key       (o_out.item.key_out),
    .i_last      (o_out.item.last)
);

FILE: tb/sv/tb_top.sv
// Self-checking bench for the slot pool with idle eviction: request, return, tick, clear.
// Predicts every result from a local copy of the pool state; needs rpie_pkg, rpie_if and the RTL.
`timescale 1ns / 1ps

module tb_top;
    import rpie_pkg::*;

    localparam int POOL_DEPTH = 16;
    localparam int SETTLE_CYCLES = POOL_DEPTH + 4;
    localparam longint LIMIT_NS = 20_000_000;
    localparam int PRINT_CAP = 60;
    localparam logic [ADDR_W-1:0] MAX_IDLE_ADDR = ADDR_W'(0);

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    rpie_in_if  in_ch ();
    rpie_out_if out_ch ();

    resource_pool_idle_eviction_core #(
        .POOL_DEPTH(POOL_DEPTH),
        .KEY_WIDTH (KEY_W)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    // Local copy of the pool.
    logic               pool_valid [POOL_DEPTH];
    logic               pool_busy  [POOL_DEPTH];
    logic [KEY_W-1:0]   pool_key   [POOL_DEPTH];
    logic [FRAME_W-1:0] pool_frame [POOL_DEPTH];
    logic [DATA_W-1:0]  idle_limit;

    t_out_item          pool_replies_q[$];
    t_out_item          want_reply;
    int                 err_count;
    bit                 steady_mode;
    int                 rx_hold;
    int                 rx_stall;
    logic [FRAME_W-1:0] frame_now;
    logic [KEY_W-1:0]   key_pool[8];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (err_count < PRINT_CAP)
            $display("[%0t] mismatch %s: got %h want %h", $time, what, got, want);
        err_count++;
    endtask

    function automatic int draw_gap();
        int r;
        if (steady_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void pool_reset();
        for (int i = 0; i < POOL_DEPTH; i++) begin
            pool_valid[i] = 1'b0;
            pool_busy[i]  = 1'b0;
            pool_key[i]   = '0;
            pool_frame[i] = '0;
        end
        idle_limit = MAX_IDLE_RESET;
    endfunction

    // Update the pool copy and queue the results this operation produces.
    function automatic void apply_pool_op(input t_in_item op);
        t_out_item          batch[$];
        t_out_item          r;
        logic [FRAME_W-1:0] age;
        int                 hit;
        int                 empty;
        hit   = -1;
        empty = -1;
        r     = '0;
        case (op.func)
            FN_REQUEST: begin
                for (int i = 0; i < POOL_DEPTH; i++) begin
                    if (hit < 0 && pool_valid[i] && !pool_busy[i] && pool_key[i] == op.key)
                        hit = i;
                    if (empty < 0 && !pool_valid[i])
                        empty = i;
                end
                r.key_out = op.key;
                if (hit >= 0) begin
                    pool_busy[hit]  = 1'b1;
                    pool_frame[hit] = op.frame;
                    r.status        = ST_REUSED;
                    r.slot_out      = SLOT_W'(hit);
                end else if (empty >= 0) begin
                    pool_valid[empty] = 1'b1;
                    pool_busy[empty]  = 1'b1;
                    pool_key[empty]   = op.key;
                    pool_frame[empty] = op.frame;
                    r.status          = ST_NEW;
                    r.slot_out        = SLOT_W'(empty);
                end else begin
                    r.status = ST_FULL;
                end
                batch = {batch, r};
            end
            FN_RETURN: begin
                if (!op.slot_in_valid) begin
                    r.status = ST_IGNORED;
                end else if (pool_valid[op.slot_in]) begin
                    pool_busy[op.slot_in] = 1'b0;
                    r.status   = ST_RETURNED;
                    r.slot_out = op.slot_in;
                    r.key_out  = pool_key[op.slot_in];
                end else begin
                    r.status   = ST_NOT_FOUND;
                    r.slot_out = op.slot_in;
                end
                batch = {batch, r};
            end
            default: begin
                for (int i = 0; i < POOL_DEPTH; i++) begin
                    // age wraps modulo 2^32
                    age = op.frame - pool_frame[i];
                    if (pool_valid[i] && (op.func == FN_CLEAR ||
                                          (!pool_busy[i] && age > idle_limit))) begin
                        r.status   = ST_EVICTED;
                        r.slot_out = SLOT_W'(i);
                        r.key_out  = pool_key[i];
                        batch = {batch, r};
                        pool_valid[i] = 1'b0;
                        pool_busy[i]  = 1'b0;
                    end
                end
                if (batch.size() == 0) begin
                    r        = '0;
                    r.status = ST_NONE;
                    batch = {batch, r};
                end
            end
        endcase
        batch[batch.size() - 1].last = 1'b1;
        foreach (batch[k])
            pool_replies_q = {pool_replies_q, batch[k]};
    endfunction

    task automatic send_op(input t_in_item op);
        int gap;
        gap = draw_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.item  = op;
        in_ch.valid = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        apply_pool_op(op);
    endtask

    task automatic send_fields(input t_func fn, input logic [KEY_W-1:0] key,
                               input logic [FRAME_W-1:0] frame,
                               input logic [SLOT_W-1:0] slot, input logic slot_ok);
        t_in_item op;
        op.func          = fn;
        op.key           = key;
        op.frame         = frame;
        op.slot_in       = slot;
        op.slot_in_valid = slot_ok;
        send_op(op);
    endtask

    // Drop valid, then hold until every queued result has been seen and the walk is over.
    task automatic wait_drained();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pool_replies_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_access(input logic wr, input logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = MAX_IDLE_ADDR;
        pwdata  = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        if (wr)
            idle_limit = wdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic program_idle_limit(input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] rd;
        cfg_access(1'b1, value, rd);
        cfg_access(1'b0, '0, rd);
        if (rd !== value)
            flag_mismatch("max_idle_frames readback", rd, value);
    endtask

    task automatic test_register_reset();
        logic [DATA_W-1:0] rd;
        cfg_access(1'b0, '0, rd);
        if (rd !== MAX_IDLE_RESET)
            flag_mismatch("max_idle_frames after reset", rd, MAX_IDLE_RESET);
    endtask

    // Runs with the reset idle limit of 3.
    task automatic test_directed_ops();
        send_fields(FN_REQUEST, 32'h0000_0000, 32'h0000_0000, 4'h0, 1'b0);
        send_fields(FN_REQUEST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 1'b1);
        // same key while its slot is busy: claim a fresh slot
        send_fields(FN_REQUEST, 32'h0000_0000, 32'h0000_0001, 4'h0, 1'b0);
        send_fields(FN_RETURN,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'h0, 1'b1);
        send_fields(FN_REQUEST, 32'h0000_0000, 32'h0000_0002, 4'h5, 1'b1);
        send_fields(FN_RETURN,  32'h1234_5678, 32'h0, 4'hF, 1'b0);
        send_fields(FN_RETURN,  32'h0, 32'h0, 4'hF, 1'b1);
        // return the same slot twice
        send_fields(FN_RETURN,  32'h0, 32'h0, 4'h1, 1'b1);
        send_fields(FN_RETURN,  32'h0, 32'h0, 4'h1, 1'b1);
        send_fields(FN_RETURN,  32'h0, 32'h0, 4'h2, 1'b1);
        // slot 1 ages across the frame wrap
        send_fields(FN_TICK,    32'hA5A5_A5A5, 32'h0000_0003, 4'hA, 1'b1);
        send_fields(FN_TICK,    32'h5A5A_5A5A, 32'h0000_0005, 4'h5, 1'b0);
        send_fields(FN_TICK,    32'h0, 32'h0000_0005, 4'h0, 1'b0);
        // clear takes the busy slot too
        send_fields(FN_CLEAR,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 1'b1);
        send_fields(FN_CLEAR,   32'h0, 32'h0, 4'h0, 1'b0);
        wait_drained();
    endtask

    // Hold off the result side while requests pile up past a full pool.
    task automatic test_stall_fill();
        logic [KEY_W-1:0] base_key;
        base_key  = $urandom;
        frame_now = 32'd100;
        send_fields(FN_CLEAR, $urandom, $urandom, SLOT_W'($urandom), 1'($urandom));
        rx_hold = 400;
        for (int k = 0; k < POOL_DEPTH + 3; k++)
            send_fields(FN_REQUEST, base_key + k, frame_now, SLOT_W'($urandom),
                        1'($urandom));
        wait_drained();
        send_fields(FN_CLEAR, $urandom, $urandom, SLOT_W'($urandom), 1'($urandom));
        wait_drained();
    endtask

    task automatic run_random_phase(input int count);
        t_in_item op;
        int       r;
        int       busy_slots[$];
        for (int n = 0; n < count; n++) begin
            op.key           = $urandom;
            op.frame         = $urandom;
            op.slot_in       = SLOT_W'($urandom);
            op.slot_in_valid = 1'($urandom);
            r = $urandom_range(0, 99);
            if (r < 40) begin
                op.func  = FN_REQUEST;
                if ($urandom_range(0, 9) != 0)
                    op.key = key_pool[$urandom_range(0, 7)];
                op.frame  = frame_now;
                frame_now = frame_now + $urandom_range(0, 3);
            end else if (r < 75) begin
                op.func = FN_RETURN;
                busy_slots.delete();
                for (int i = 0; i < POOL_DEPTH; i++)
                    if (pool_valid[i] && pool_busy[i])
                        busy_slots = {busy_slots, i};
                if (busy_slots.size() > 0 && $urandom_range(0, 9) < 8) begin
                    op.slot_in       = SLOT_W'(busy_slots[$urandom_range(0,
                                                              busy_slots.size() - 1)]);
                    op.slot_in_valid = 1'b1;
                end
            end else if (r < 95) begin
                op.func = FN_TICK;
                if ($urandom_range(0, 9) == 0)
                    frame_now = frame_now + $urandom;
                else
                    frame_now = frame_now + $urandom_range(0, 6);
                op.frame = frame_now;
            end else if (r < 98) begin
                op.func = FN_CLEAR;
            end else begin
                // out-of-sequence item with a stray frame
                op.func = t_func'($urandom_range(0, 3));
            end
            send_op(op);
        end
    endtask

    task automatic test_random_limits();
        logic [DATA_W-1:0] limits[6];
        limits[0] = '0;
        limits[1] = '1;
        limits[2] = $urandom_range(1, 8);
        limits[3] = $urandom;
        limits[4] = $urandom_range(0, 2);
        limits[5] = MAX_IDLE_RESET;
        foreach (limits[p]) begin
            program_idle_limit(limits[p]);
            key_pool[0] = '0;
            key_pool[1] = '1;
            for (int k = 2; k < 8; k++)
                key_pool[k] = $urandom;
            frame_now   = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFF0;
            steady_mode = (p == 2);
            run_random_phase(48);
            steady_mode = 1'b0;
            wait_drained();
        end
    endtask

    // Result side: random stalls, or a long hold when one is requested.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                out_ch.ready = 1'b0;
                rx_hold--;
            end else begin
                if (rx_stall == 0 && $urandom_range(0, 99) < 20)
                    rx_stall = draw_gap();
                if (rx_stall > 0) begin
                    out_ch.ready = 1'b0;
                    rx_stall--;
                end else begin
                    out_ch.ready = 1'b1;
                end
            end
        end
    end

    // Compare each transfer on the result side with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pool_replies_q.size() == 0) begin
                flag_mismatch("unrequested result status", 32'(out_ch.item.status), 0);
            end else begin
                want_reply = pool_replies_q.pop_front();
                if (out_ch.item.status !== want_reply.status)
                    flag_mismatch("status", 32'(out_ch.item.status), 32'(want_reply.status));
                if (out_ch.item.slot_out !== want_reply.slot_out)
                    flag_mismatch("slot_out", 32'(out_ch.item.slot_out),
                                  32'(want_reply.slot_out));
                if (out_ch.item.key_out !== want_reply.key_out)
                    flag_mismatch("key_out", out_ch.item.key_out, want_reply.key_out);
                if (out_ch.item.last !== want_reply.last)
                    flag_mismatch("last", 32'(out_ch.item.last), 32'(want_reply.last));
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.item  = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        err_count   = 0;
        steady_mode = 1'b0;
        rx_hold     = 0;
        rx_stall    = 0;
        frame_now   = '0;
        pool_reset();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_register_reset();
        test_directed_ops();
        test_stall_fill();
        test_random_limits();
        wait_drained();

        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
